// ----- rtl/rhc_pkg.sv -----
// Shared types, constants and the divider step function for the RGB to HSL converter.
package rhc_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QBITS       = 9;   // quotient bits per divider lane
   localparam int unsigned NUM_W       = 18;  // partial remainder width
   localparam int unsigned DEN_W       = 9;   // divisor width
   localparam int unsigned LIGHT_X_W   = 17;  // width of 200*sum + 510
   localparam int unsigned LIGHT_SHIFT = 27;
   localparam logic [17:0] LIGHT_MULT  = 18'd131587; // ceil(2^27 / 1020)
   localparam logic [8:0]  HUE_WRAP    = 9'd360;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [8:0] hue_degrees;
      logic [6:0] saturation_pct;
      logic [6:0] lightness_pct;
   } rsp_type;

   // Classified pixel: two rounding divisions still to do.
   typedef struct packed {
      logic [NUM_W-1:0] hue_num;
      logic [DEN_W-1:0] hue_den;
      logic [NUM_W-1:0] sat_num;
      logic [DEN_W-1:0] sat_den;
      logic             grey;
      logic [6:0]       light;
   } work_type;

   // One stage of the two restoring dividers.
   typedef struct packed {
      logic [NUM_W-1:0] rem_h;
      logic [QBITS-1:0] q_h;
      logic [DEN_W-1:0] den_h;
      logic [NUM_W-1:0] rem_s;
      logic [QBITS-1:0] q_s;
      logic [DEN_W-1:0] den_s;
      logic             grey;
      logic [6:0]       light;
   } stage_type;

   function automatic stage_type div_step(stage_type s, int unsigned bitpos);
      stage_type         o;
      logic [NUM_W-1:0]  sh_h;
      logic [NUM_W-1:0]  sh_s;
      o    = s;
      sh_h = NUM_W'(s.den_h) << bitpos;
      sh_s = NUM_W'(s.den_s) << bitpos;
      if (s.rem_h >= sh_h) begin
         o.rem_h          = s.rem_h - sh_h;
         o.q_h[bitpos]    = 1'b1;
      end
      if (s.rem_s >= sh_s) begin
         o.rem_s          = s.rem_s - sh_s;
         o.q_s[bitpos]    = 1'b1;
      end
      return o;
   endfunction

endpackage

// ----- rtl/rhc_front.sv -----
// Front end: finds max and min, picks the hue sector, forms the rounding fractions and computes the lightness.
module rhc_front (
   input  rhc_pkg::req_type  pixel,
   output rhc_pkg::work_type work
);
   import rhc_pkg::*;

   logic [7:0]           mx, mn, d;
   logic [8:0]           sum, den;
   logic [1:0]           sector;
   logic signed [18:0]   t, ds;
   logic [LIGHT_X_W-1:0] light_x;
   logic [34:0]          light_prod;

   always_comb begin
      mx     = pixel.red;
      mn     = pixel.red;
      sector = 2'd0;
      if (pixel.green > mx) begin
         mx     = pixel.green;
         sector = 2'd1;
      end
      if (pixel.blue > mx) begin
         mx     = pixel.blue;
         sector = 2'd2;
      end
      if (pixel.green < mn) mn = pixel.green;
      if (pixel.blue < mn) mn = pixel.blue;
      d   = mx - mn;
      sum = 9'(mx) + 9'(mn);
      den = (sum <= 9'd255) ? sum : 9'(9'd510 - sum);
      ds  = $signed({11'b0, d});

      unique case (sector)
         2'd0: begin
            t = 19'sd60 * ($signed({11'b0, pixel.green}) - $signed({11'b0, pixel.blue}));
            if (t < 0) t = t + 19'sd360 * ds;
         end
         2'd1: t = 19'sd120 * ds
                   + 19'sd60 * ($signed({11'b0, pixel.blue}) - $signed({11'b0, pixel.red}));
         default: t = 19'sd240 * ds
                   + 19'sd60 * ($signed({11'b0, pixel.red}) - $signed({11'b0, pixel.green}));
      endcase

      // Rounded lightness: floor((200*sum + 510) / 1020) by reciprocal multiply.
      light_x    = LIGHT_X_W'(LIGHT_X_W'(17'd200 * 17'(sum)) + 17'd510);
      light_prod = 35'(light_x) * 35'(LIGHT_MULT);

      work.hue_num = NUM_W'(2 * t) + NUM_W'(d);
      work.hue_den = {d, 1'b0};
      work.sat_num = NUM_W'(18'd200 * 18'(d)) + NUM_W'(den);
      work.sat_den = {den[7:0], 1'b0};
      work.grey    = (d == 8'd0);
      work.light   = light_prod[LIGHT_SHIFT +: 7];
   end

endmodule

// ----- rtl/rhc_queue.sv -----
// Short register queue that decouples the front end from the divider pipeline.
module rhc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rhc_pkg::work_type wdata,
   output logic              full,
   input  logic              pop,
   output rhc_pkg::work_type rdata,
   output logic              empty
);
   import rhc_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   work_type       mem_ff [DEPTH];
   logic [PW-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wptr_ff + 1'b1);
      if (do_pop)  rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rptr_ff + 1'b1);
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) mem_ff[wptr_ff] <= wdata;
   end

endmodule

// ----- rtl/rhc_back.sv -----
// Back end: two pipelined restoring dividers, one quotient bit per stage, and the result fix-ups.
module rhc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rhc_pkg::work_type in_work,
   output logic              in_ready,
   output logic              out_valid,
   output rhc_pkg::rsp_type  out_rsp,
   input  logic              out_ready
);
   import rhc_pkg::*;

   stage_type stg_ff [QBITS];
   stage_type stg_in [QBITS];
   logic      vld_ff [QBITS];
   logic      rdy    [QBITS+1];
   stage_type first;
   stage_type last;

   always_comb begin
      first       = '0;
      first.rem_h = in_work.hue_num;
      first.den_h = in_work.hue_den;
      first.rem_s = in_work.sat_num;
      first.den_s = in_work.sat_den;
      first.grey  = in_work.grey;
      first.light = in_work.light;
   end

   assign rdy[QBITS] = out_ready;
   assign in_ready   = rdy[0];

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
      if (k == 0) begin : g_head
         assign stg_in[k] = div_step(first, QBITS - 1);
      end else begin : g_body
         assign stg_in[k] = div_step(stg_ff[k-1], QBITS - 1 - k);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k-1];
         end
         if (rdy[k]) stg_ff[k] <= stg_in[k];
      end
   end

   assign last      = stg_ff[QBITS-1];
   assign out_valid = vld_ff[QBITS-1];

   always_comb begin
      out_rsp.lightness_pct  = last.light;
      // A grey pixel has no hue or saturation; a hue that rounds to a full turn is zero.
      out_rsp.hue_degrees    = (last.grey || last.q_h >= HUE_WRAP) ? '0 : last.q_h;
      out_rsp.saturation_pct = last.grey ? '0 : last.q_s[6:0];
   end

endmodule

// ----- rtl/rgb_to_hsl_converter.sv -----
// Top level of the RGB to HSL converter: front end, queue and divider pipeline.
//
// Converts one 8-bit RGB pixel per request into hue in whole degrees (0 to 359) and
// saturation and lightness in whole percent (0 to 100), each rounded half up from the
// exact rational value. A grey pixel gives hue and saturation of zero. The block takes
// one request per clock and delivers one result per clock when the consumer keeps
// popping; an accepted request waits in the queue and then passes through the
// nine-stage divider pipeline that produces one quotient bit per stage. The front end
// classifies a pixel in the cycle it is accepted and writes it into a four-entry queue,
// so the input keeps flowing while the result side is briefly stalled; each pipeline
// stage holds its request until the next stage can take it, and the last stage drives
// the result ports directly.
module rgb_to_hsl_converter #(
   parameter int unsigned QUEUE_DEPTH = rhc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  rhc_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   output rhc_pkg::rsp_type rsp_data,
   input  logic             rsp_pop
);
   import rhc_pkg::*;

   work_type work_new;
   work_type work_head;
   logic     q_empty;
   logic     q_pop;
   logic     out_valid;

   // Classification is purely combinational; the queue is its register.
   rhc_front u_front (
      .pixel (req_data),
      .work  (work_new)
   );

   rhc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (work_new),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (work_head),
      .empty (q_empty)
   );

   // The divider pipeline takes the queue head whenever its first stage can move.
   rhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_work   (work_head),
      .in_ready  (q_pop),
      .out_valid (out_valid),
      .out_rsp   (rsp_data),
      .out_ready (rsp_pop)
   );

   assign rsp_empty = !out_valid;

endmodule
